// ===== src/dsts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsts_pkg: shared types and constants of the Dirichlet top-K scan core
// Field widths, request mode codes, register indexes, fixed-point constants.
// ----------------------------------------------------------------------------
package dsts_pkg;

   // field widths
   localparam int ModeW    = 2;
   localparam int SlotW    = 4;
   localparam int TermW    = 32;
   localparam int WeightW  = 16;
   localparam int TfW      = 16;
   localparam int CfW      = 32;
   localparam int LenW     = 16;
   localparam int IdW      = 63;
   localparam int RankW    = 7;
   localparam int IndexW   = 24;
   localparam int ScoreW   = 32;
   localparam int MuW      = 16;
   localparam int TotalW   = 40;
   localparam int QlenW    = 5;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 63;

   // request modes
   typedef logic [ModeW-1:0] mode_type;
   localparam mode_type MODE_LOAD    = 2'd0;
   localparam mode_type MODE_POSTING = 2'd1;
   localparam mode_type MODE_FLUSH   = 2'd2;

   // register indexes
   typedef logic [CsrAddrW-1:0] csr_index_type;
   localparam csr_index_type CSR_MU     = 2'd0;
   localparam csr_index_type CSR_TOTAL  = 2'd1;
   localparam csr_index_type CSR_CUTOFF = 2'd2;
   localparam csr_index_type CSR_QLEN   = 2'd3;

   // register reset values
   localparam logic [MuW-1:0] MU_RESET     = 16'd2500;
   localparam logic [IdW-1:0] CUTOFF_RESET = {IdW{1'b1}};

   // ln(2) in Q0.32 and log2 fraction bits
   localparam logic [31:0] LN2_Q32      = 32'hB17217F8;
   localparam int          LnFracBits   = 16;

endpackage

// ===== src/dsts_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsts_req_if: request channel of the Dirichlet top-K scan core
// Valid/ready channel carrying load, posting and flush requests.
// ----------------------------------------------------------------------------
interface dsts_req_if import dsts_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ModeW-1:0]     mode;
   logic [SlotW-1:0]     slot;
   logic [TermW-1:0]     term_id;
   logic [WeightW-1:0]   query_weight;
   logic [TfW-1:0]       term_freq;
   logic [CfW-1:0]       coll_freq;
   logic [LenW-1:0]      doc_length;
   logic [IdW-1:0]       doc_id;
   logic                 doc_last;

   modport source (output valid, mode, slot, term_id, query_weight, term_freq,
                   coll_freq, doc_length, doc_id, doc_last, input ready);
   modport sink   (input valid, mode, slot, term_id, query_weight, term_freq,
                   coll_freq, doc_length, doc_id, doc_last, output ready);
endinterface

// ===== src/dsts_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsts_rsp_if: result channel of the Dirichlet top-K scan core
// Valid/ready channel carrying ranked documents during a flush.
// ----------------------------------------------------------------------------
interface dsts_rsp_if import dsts_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [RankW-1:0]         rank;
   logic [IndexW-1:0]        doc_index;
   logic [IdW-1:0]           result_id;
   logic signed [ScoreW-1:0] score;
   logic                     last;

   modport source (output valid, rank, doc_index, result_id, score, last,
                   input ready);
   modport sink   (input valid, rank, doc_index, result_id, score, last,
                   output ready);
endinterface

// ===== src/dirichlet_score_top_k_scan_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirichlet_score_top_k_scan_core: Dirichlet query-likelihood top-K scanner
// Scores postings against a loaded query and keeps the best documents.
// ----------------------------------------------------------------------------
// One request is handled at a time; req ready is high only when the core is
// idle. A load or mode-three request completes in its accept cycle. A posting
// passes the accept cycle, a search over the query slots and a closing state;
// a matching posting then runs four fixed-point logarithms on a single shared
// 33x33 multiplier, each made of a setup, normalize shifts and a final check,
// 16 squaring steps and one scale, between the products and the weighting,
// accumulation and document end. A flush delivers one result per cycle while
// the result side takes them, then returns to idle. There is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module dirichlet_score_top_k_scan_core import dsts_pkg::*; #(
   parameter int TOP_COUNT       = 16,
   parameter int MAX_QUERY_TERMS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   dsts_req_if.sink             req_if,
   dsts_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [CsrAddrW-1:0]  csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   localparam int QCW = $clog2(MAX_QUERY_TERMS + 1);
   localparam int QIW = (MAX_QUERY_TERMS > 1) ? $clog2(MAX_QUERY_TERMS) : 1;
   localparam int KCW = $clog2(TOP_COUNT + 1);
   localparam int KIW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
   localparam int VW  = 58;   // widest logarithm operand, d + n
   localparam int EW  = 6;
   localparam int SW  = 26;   // log sum
   localparam int CW  = 36;   // weighted contribution

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEARCH, ST_MUL_D, ST_MUL_NLO, ST_MUL_NHI, ST_LN_INIT,
      ST_LN_NORM, ST_LN_SQ, ST_LN_SCALE, ST_WMUL, ST_ACC, ST_DOC_END, ST_FLUSH
   } state_type;

   state_type state_ff;

   // configuration
   logic [MuW-1:0]    mu_ff;
   logic [TotalW-1:0] total_ff;
   logic [IdW-1:0]    cutoff_ff;
   logic [QlenW-1:0]  qlen_ff;

   // query and kept store
   logic [TermW-1:0]         qterm_ff   [MAX_QUERY_TERMS];
   logic [WeightW-1:0]       qweight_ff [MAX_QUERY_TERMS];
   logic signed [ScoreW-1:0] kscore_ff  [TOP_COUNT];
   logic [IndexW-1:0]        kindex_ff  [TOP_COUNT];
   logic [IdW-1:0]           kid_ff     [TOP_COUNT];
   logic [KCW-1:0]           kcount_ff;
   logic signed [ScoreW-1:0] thr_ff;
   logic signed [ScoreW-1:0] acc_ff;
   logic [IndexW-1:0]        doc_cnt_ff;

   // latched posting
   logic [TermW-1:0]   term_ff;
   logic [TfW-1:0]     tf_ff;
   logic [CfW-1:0]     cf_ff;
   logic [LenW-1:0]    len_ff;
   logic [IdW-1:0]     id_ff;
   logic               dlast_ff;
   logic [WeightW-1:0] w_ff;
   logic [QCW-1:0]     t_ff;

   // arithmetic
   logic [48:0]           d_ff;
   logic [47:0]           nlo_ff;
   logic [56:0]           num_ff;
   logic [VW-1:0]         nv_ff;
   logic [EW-1:0]         e_ff;
   logic [31:0]           z_ff;
   logic [LnFracBits-1:0] frac_ff;
   logic [3:0]            iter_ff;
   logic [1:0]            which_ff;
   logic signed [SW-1:0]  s_ff;
   logic signed [CW-1:0]  c_ff;
   logic [KIW-1:0]        k_ff;

   // result register
   logic                     rsp_valid_ff;
   logic [RankW-1:0]         rank_ff;
   logic [IndexW-1:0]        rindex_ff;
   logic [IdW-1:0]           rid_ff;
   logic signed [ScoreW-1:0] rscore_ff;
   logic                     rlast_ff;

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.rank      = rank_ff;
   assign rsp_if.doc_index = rindex_ff;
   assign rsp_if.result_id = rid_ff;
   assign rsp_if.score     = rscore_ff;
   assign rsp_if.last      = rlast_ff;

   // result register takes a new entry when empty or being drained
   logic rsp_load;
   assign rsp_load = (state_ff == ST_FLUSH) && (!rsp_valid_ff || rsp_if.ready);

   // effective settings
   logic [MuW-1:0]    m_eff;
   logic [TotalW:0]   tp1;
   logic [QCW-1:0]    n_eff;
   logic [QIW+SlotW-1:0] slot_ext;
   assign m_eff    = (mu_ff == '0) ? MuW'(1) : mu_ff;
   assign tp1      = (TotalW+1)'(total_ff) + (TotalW+1)'(1);
   assign n_eff    = (int'(qlen_ff) > MAX_QUERY_TERMS) ? QCW'(MAX_QUERY_TERMS)
                                                      : QCW'(qlen_ff);
   assign slot_ext = (QIW+SlotW)'(req_if.slot);

   // shared multiplier
   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_p;
   logic        s_neg;
   logic [SW-1:0] s_mag;
   assign s_neg = s_ff[SW-1];
   assign s_mag = s_neg ? SW'(-s_ff) : SW'(s_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_D: begin
            mul_a = 33'(m_eff);
            mul_b = 33'(cf_ff) + 33'd1;
         end
         ST_MUL_NLO: begin
            mul_a = 33'(tf_ff);
            mul_b = 33'(tp1[31:0]);
         end
         ST_MUL_NHI: begin
            mul_a = 33'(tf_ff);
            mul_b = 33'(tp1[TotalW:32]);
         end
         ST_LN_SQ: begin
            mul_a = 33'(z_ff);
            mul_b = 33'(z_ff);
         end
         ST_LN_SCALE: begin
            mul_a = 33'({e_ff, frac_ff});
            mul_b = 33'(LN2_Q32);
         end
         ST_WMUL: begin
            mul_a = 33'(s_mag);
            mul_b = 33'(w_ff);
         end
         default: ;
      endcase
      mul_p = 66'(mul_a) * 66'(mul_b);
   end

   // derived arithmetic terms
   logic [32:0]          sq;
   logic [65:0]          ln_sum;
   logic signed [SW-1:0] ln_val;
   logic [42:0]          p_round;
   logic signed [CW+0:0] acc_sum;
   logic [VW-1:0]        ln_opnd;
   assign sq      = mul_p[63:31];
   assign ln_sum  = mul_p + 66'h8000_0000;
   assign ln_val  = SW'(ln_sum[55:32]);
   assign p_round = 43'(mul_p[41:0]) + 43'd255;
   assign acc_sum = (CW+1)'(acc_ff) + (CW+1)'(c_ff);

   always_comb begin
      unique case (which_ff)
         2'd0:    ln_opnd = VW'(d_ff) + VW'(num_ff);
         2'd1:    ln_opnd = VW'(d_ff);
         2'd2:    ln_opnd = VW'(m_eff);
         default: ln_opnd = VW'(len_ff) + VW'(m_eff);
      endcase
   end

   // top-K insertion, all entries compared at once
   logic signed [ScoreW-1:0] kscore_in [TOP_COUNT];
   logic [IndexW-1:0]        kindex_in [TOP_COUNT];
   logic [IdW-1:0]           kid_in    [TOP_COUNT];
   logic                     full;
   logic                     offer_ok;

   assign full     = (int'(kcount_ff) >= TOP_COUNT);
   assign offer_ok = (acc_ff > 0) && (!full || (acc_ff > thr_ff));

   always_comb begin
      int pos;
      int ju;
      int jd;
      pos = 0;
      for (int j = 0; j < TOP_COUNT; j++) begin
         if ((j < int'(kcount_ff)) && (kscore_ff[j] <= acc_ff)) pos = pos + 1;
      end
      for (int j = 0; j < TOP_COUNT; j++) begin
         ju = (j < TOP_COUNT - 1) ? j + 1 : j;
         jd = (j > 0) ? j - 1 : 0;
         kscore_in[j] = kscore_ff[j];
         kindex_in[j] = kindex_ff[j];
         kid_in[j]    = kid_ff[j];
         if (full) begin
            if (j + 1 < pos) begin
               kscore_in[j] = kscore_ff[ju];
               kindex_in[j] = kindex_ff[ju];
               kid_in[j]    = kid_ff[ju];
            end else if (j + 1 == pos) begin
               kscore_in[j] = acc_ff;
               kindex_in[j] = doc_cnt_ff;
               kid_in[j]    = id_ff;
            end
         end else begin
            if (j == pos) begin
               kscore_in[j] = acc_ff;
               kindex_in[j] = doc_cnt_ff;
               kid_in[j]    = id_ff;
            end else if ((j > pos) && (j <= int'(kcount_ff))) begin
               kscore_in[j] = kscore_ff[jd];
               kindex_in[j] = kindex_ff[jd];
               kid_in[j]    = kid_ff[jd];
            end
         end
      end
   end

   logic [KCW-1:0] kcount_in;
   logic [KCW-1:0] k_ext;
   assign kcount_in = full ? KCW'(TOP_COUNT) : kcount_ff + KCW'(1);
   assign k_ext     = KCW'(k_ff);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mu_ff        <= MU_RESET;
         total_ff     <= '0;
         cutoff_ff    <= CUTOFF_RESET;
         qlen_ff      <= '0;
         kcount_ff    <= '0;
         thr_ff       <= '0;
         acc_ff       <= '0;
         doc_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_MU:     mu_ff     <= csr_wdata[MuW-1:0];
               CSR_TOTAL:  total_ff  <= csr_wdata[TotalW-1:0];
               CSR_CUTOFF: cutoff_ff <= csr_wdata[IdW-1:0];
               CSR_QLEN:   qlen_ff   <= csr_wdata[QlenW-1:0];
            endcase
         end

         if (rsp_if.ready && !rsp_load) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  unique case (req_if.mode)
                     MODE_LOAD: begin
                        if (int'(req_if.slot) < MAX_QUERY_TERMS) begin
                           qterm_ff[slot_ext[QIW-1:0]]   <= req_if.term_id;
                           qweight_ff[slot_ext[QIW-1:0]] <= req_if.query_weight;
                        end
                     end
                     MODE_POSTING: begin
                        term_ff  <= req_if.term_id;
                        tf_ff    <= req_if.term_freq;
                        cf_ff    <= req_if.coll_freq;
                        len_ff   <= req_if.doc_length;
                        id_ff    <= req_if.doc_id;
                        dlast_ff <= req_if.doc_last;
                        t_ff     <= '0;
                        if (req_if.doc_id <= cutoff_ff) state_ff <= ST_SEARCH;
                     end
                     MODE_FLUSH: begin
                        k_ff <= '0;
                        if (kcount_ff == '0) begin
                           thr_ff     <= '0;
                           doc_cnt_ff <= '0;
                        end else begin
                           state_ff <= ST_FLUSH;
                        end
                     end
                     default: ;
                  endcase
               end
            end

            // lowest matching slot wins
            ST_SEARCH: begin
               if (t_ff == n_eff) begin
                  state_ff <= ST_DOC_END;
               end else if (qterm_ff[t_ff[QIW-1:0]] == term_ff) begin
                  w_ff     <= qweight_ff[t_ff[QIW-1:0]];
                  state_ff <= ST_MUL_D;
               end else begin
                  t_ff <= t_ff + QCW'(1);
               end
            end

            ST_MUL_D: begin
               d_ff     <= mul_p[48:0];
               state_ff <= ST_MUL_NLO;
            end

            ST_MUL_NLO: begin
               nlo_ff   <= mul_p[47:0];
               state_ff <= ST_MUL_NHI;
            end

            ST_MUL_NHI: begin
               num_ff   <= 57'(nlo_ff) + {mul_p[24:0], 32'd0};
               which_ff <= 2'd0;
               s_ff     <= '0;
               state_ff <= ST_LN_INIT;
            end

            ST_LN_INIT: begin
               nv_ff    <= ln_opnd;
               e_ff     <= EW'(VW - 1);
               state_ff <= ST_LN_NORM;
            end

            // bring the top set bit to the msb
            ST_LN_NORM: begin
               if (nv_ff[VW-1]) begin
                  z_ff     <= nv_ff[VW-1 -: 32];
                  frac_ff  <= '0;
                  iter_ff  <= '0;
                  state_ff <= ST_LN_SQ;
               end else if (nv_ff[VW-1 -: 8] == 8'd0) begin
                  nv_ff <= nv_ff << 8;
                  e_ff  <= e_ff - EW'(8);
               end else begin
                  nv_ff <= nv_ff << 1;
                  e_ff  <= e_ff - EW'(1);
               end
            end

            // one log2 fraction bit per squaring
            ST_LN_SQ: begin
               if (sq[32]) begin
                  z_ff    <= sq[32:1];
                  frac_ff <= {frac_ff[LnFracBits-2:0], 1'b1};
               end else begin
                  z_ff    <= sq[31:0];
                  frac_ff <= {frac_ff[LnFracBits-2:0], 1'b0};
               end
               iter_ff <= iter_ff + 4'd1;
               if (iter_ff == 4'(LnFracBits - 1)) state_ff <= ST_LN_SCALE;
            end

            // log2 to ln; even operands add, odd subtract
            ST_LN_SCALE: begin
               s_ff     <= which_ff[0] ? s_ff - ln_val : s_ff + ln_val;
               which_ff <= which_ff + 2'd1;
               state_ff <= (which_ff == 2'd3) ? ST_WMUL : ST_LN_INIT;
            end

            // weight in Q8.8, floor division by 256
            ST_WMUL: begin
               c_ff     <= s_neg ? -$signed(CW'(p_round[42:8]))
                                 : $signed(CW'(mul_p[41:8]));
               state_ff <= ST_ACC;
            end

            ST_ACC: begin
               if (acc_sum[CW:ScoreW-1] != '0 && acc_sum[CW:ScoreW-1] != '1)
                  acc_ff <= acc_sum[CW] ? {1'b1, {(ScoreW-1){1'b0}}}
                                        : {1'b0, {(ScoreW-1){1'b1}}};
               else
                  acc_ff <= acc_sum[ScoreW-1:0];
               state_ff <= ST_DOC_END;
            end

            ST_DOC_END: begin
               if (dlast_ff) begin
                  if (acc_ff > 0) begin
                     if (offer_ok) begin
                        for (int j = 0; j < TOP_COUNT; j++) begin
                           kscore_ff[j] <= kscore_in[j];
                           kindex_ff[j] <= kindex_in[j];
                           kid_ff[j]    <= kid_in[j];
                        end
                        kcount_ff <= kcount_in;
                        if (int'(kcount_in) == TOP_COUNT) thr_ff <= kscore_in[0];
                     end
                     acc_ff <= '0;
                  end
                  doc_cnt_ff <= doc_cnt_ff + IndexW'(1);
               end
               state_ff <= ST_IDLE;
            end

            // ascending score order, one result per free result slot
            ST_FLUSH: begin
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  rank_ff      <= RankW'(TOP_COUNT) - RankW'(k_ff);
                  rindex_ff    <= kindex_ff[k_ff];
                  rid_ff       <= kid_ff[k_ff];
                  rscore_ff    <= kscore_ff[k_ff];
                  rlast_ff     <= (k_ext == kcount_ff - KCW'(1));
                  if (k_ext == kcount_ff - KCW'(1)) begin
                     kcount_ff  <= '0;
                     thr_ff     <= '0;
                     doc_cnt_ff <= '0;
                     state_ff   <= ST_IDLE;
                  end else begin
                     k_ff <= k_ff + KIW'(1);
                  end
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(kcount_ff) <= TOP_COUNT)
      else $error("kept count above capacity");

   a_thr_min: assert property (@(posedge clock) disable iff (reset)
      (int'(kcount_ff) == TOP_COUNT) |-> (thr_ff == kscore_ff[0]))
      else $error("threshold differs from smallest kept score");

   a_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LN_SQ) |-> z_ff[31])
      else $error("log mantissa lost normalization");

   for (genvar g = 1; g < TOP_COUNT; g++) begin : g_sorted
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         (int'(kcount_ff) > g) |-> (kscore_ff[g-1] <= kscore_ff[g]))
         else $error("kept store out of order");
   end
`endif

endmodule
